[rtl/sorted_key_value_table_defines.svh]
// sorted_key_value_table_defines.svh
// Assertion macros used by the checker file.
`ifndef SORTED_KEY_VALUE_TABLE_DEFINES_SVH
`define SORTED_KEY_VALUE_TABLE_DEFINES_SVH

// Same-cycle implication, sampled on clk, off during reset.
`define SKVT_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, sampled on clk, off during reset.
`define SKVT_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

[rtl/skvt_pkg.sv]
// ----------------------------------------------------------------------------
// skvt_pkg
// Types and constants of the sorted key/value table.
// ----------------------------------------------------------------------------
`default_nettype none

package skvt_pkg;

  localparam int ENTRIES_DEF = 64;

  localparam int KIND_W   = 2;
  localparam int KEY_W    = 31;
  localparam int VAL_W    = 16;
  localparam int STORED_W = 15;
  localparam int STATUS_W = 3;

  localparam logic [VAL_W-1:0] NO_VALUE = 16'hFFFF;

  localparam logic [STATUS_W-1:0] ST_DONE    = 3'd0;
  localparam logic [STATUS_W-1:0] ST_DUP     = 3'd1;
  localparam logic [STATUS_W-1:0] ST_INVALID = 3'd2;
  localparam logic [STATUS_W-1:0] ST_FULL    = 3'd3;
  localparam logic [STATUS_W-1:0] ST_ABSENT  = 3'd4;

  typedef enum logic [KIND_W-1:0] {
    KIND_LOOKUP = 2'd0,
    KIND_INSERT = 2'd1,
    KIND_REMOVE = 2'd2,
    KIND_CLEAR  = 2'd3
  } kind_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_SCAN_RD,
    S_SCAN_CMP,
    S_EXEC,
    S_INS_RD,
    S_INS_WR,
    S_RM_RD,
    S_RM_WR
  } state_t;

  typedef struct packed {
    logic [KEY_W-1:0]    key;
    logic [STORED_W-1:0] val;
  } entry_t;

endpackage

`default_nettype wire

[rtl/sorted_key_value_table.sv]
// A lookup, insert or remove scans from slot 0 up to the first key that is not
// below the search key, or to the end of the table; an insert or remove then
// moves the tail one entry at a time. A clear is done on its accept edge. The
// result register loads the held result once the output register is free.
// Throughput: one word at a time; in_stall holds off a new word while busy.
// Reset empties the table (count to zero); table contents are not cleared.
`default_nettype none

// ----------------------------------------------------------------------------
// sorted_key_value_table
// Key/value table kept in ascending key order in a one-read one-write memory,
// searched and shifted one entry at a time under a small sequencer.
// ----------------------------------------------------------------------------
module sorted_key_value_table #(
  parameter int ENTRIES = skvt_pkg::ENTRIES_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                in_valid,
  output logic                                     in_stall,
  input  wire logic [skvt_pkg::KIND_W-1:0]         in_kind,
  input  wire logic [skvt_pkg::KEY_W-1:0]          in_key,
  input  wire logic signed [skvt_pkg::VAL_W-1:0]   in_new_value,
  output logic                                     out_valid,
  input  wire logic                                out_stall,
  output logic                                     out_found,
  output logic signed [skvt_pkg::VAL_W-1:0]        out_found_value,
  output logic [skvt_pkg::STATUS_W-1:0]            out_status
);

  import skvt_pkg::*;

  localparam int AW = (ENTRIES > 1) ? $clog2(ENTRIES) : 1;
  localparam int CW = $clog2(ENTRIES + 1);
  localparam logic [CW-1:0] FULL_CNT = CW'(ENTRIES);
  localparam logic [CW-1:0] ONE      = CW'(1);

  entry_t mem [ENTRIES];
  entry_t rdata_r;
  logic           mem_we;
  logic [AW-1:0]  mem_waddr;
  logic [AW-1:0]  mem_raddr;
  entry_t         mem_wdata;

  state_t state_r, state_nxt;
  kind_t  kind_r, kind_nxt;
  logic [KEY_W-1:0] key_r, key_nxt;
  logic [VAL_W-1:0] val_r, val_nxt;
  logic [CW-1:0]    idx_r, idx_nxt;
  logic [CW-1:0]    sh_r, sh_nxt;
  logic [CW-1:0]    cnt_r, cnt_nxt;
  logic             hit_r, hit_nxt;
  logic [VAL_W-1:0] fval_r, fval_nxt;
  logic [STATUS_W-1:0] st_r, st_nxt;
  logic             done_r, done_nxt;

  logic             out_valid_r, out_valid_nxt;
  logic             out_found_r, out_found_nxt;
  logic [VAL_W-1:0] out_fval_r, out_fval_nxt;
  logic [STATUS_W-1:0] out_status_r, out_status_nxt;

  logic out_free;

  assign out_free = !out_valid_r || !out_stall;

  always_ff @(posedge clk) begin
    if (mem_we) begin
      mem[mem_waddr] <= mem_wdata;
    end
    rdata_r <= mem[mem_raddr];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      cnt_r       <= '0;
      done_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      done_r      <= done_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    kind_r       <= kind_nxt;
    key_r        <= key_nxt;
    val_r        <= val_nxt;
    idx_r        <= idx_nxt;
    sh_r         <= sh_nxt;
    hit_r        <= hit_nxt;
    fval_r       <= fval_nxt;
    st_r         <= st_nxt;
    out_found_r  <= out_found_nxt;
    out_fval_r   <= out_fval_nxt;
    out_status_r <= out_status_nxt;
  end

  always_comb begin
    state_nxt      = state_r;
    kind_nxt       = kind_r;
    key_nxt        = key_r;
    val_nxt        = val_r;
    idx_nxt        = idx_r;
    sh_nxt         = sh_r;
    cnt_nxt        = cnt_r;
    hit_nxt        = hit_r;
    fval_nxt       = fval_r;
    st_nxt         = st_r;
    done_nxt       = done_r;
    out_valid_nxt  = out_valid_r && out_stall;
    out_found_nxt  = out_found_r;
    out_fval_nxt   = out_fval_r;
    out_status_nxt = out_status_r;
    mem_we         = 1'b0;
    mem_waddr      = idx_r[AW-1:0];
    mem_wdata      = '{key: key_r, val: val_r[STORED_W-1:0]};
    mem_raddr      = idx_r[AW-1:0];
    in_stall       = 1'b1;

    // result handoff to the output register
    if (done_r && out_free) begin
      done_nxt       = 1'b0;
      out_valid_nxt  = 1'b1;
      out_found_nxt  = hit_r;
      out_fval_nxt   = fval_r;
      out_status_nxt = st_r;
    end

    case (state_r)
      S_IDLE: begin
        in_stall = done_r;
        if (in_valid && !done_r) begin
          kind_nxt = kind_t'(in_kind);
          key_nxt  = in_key;
          val_nxt  = in_new_value;
          idx_nxt  = '0;
          hit_nxt  = 1'b0;
          fval_nxt = NO_VALUE;
          st_nxt   = ST_DONE;
          if (kind_t'(in_kind) == KIND_CLEAR) begin
            cnt_nxt  = '0;
            done_nxt = 1'b1;
          end else begin
            state_nxt = S_SCAN_RD;
          end
        end
      end
      S_SCAN_RD: begin
        if (idx_r == cnt_r) begin
          state_nxt = S_EXEC;
        end else begin
          mem_raddr = idx_r[AW-1:0];
          state_nxt = S_SCAN_CMP;
        end
      end
      S_SCAN_CMP: begin
        if (rdata_r.key < key_r) begin
          idx_nxt   = idx_r + ONE;
          state_nxt = S_SCAN_RD;
        end else begin
          if (rdata_r.key == key_r) begin
            hit_nxt  = 1'b1;
            fval_nxt = {1'b0, rdata_r.val};
          end
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        state_nxt = S_IDLE;
        done_nxt  = 1'b1;
        case (kind_r)
          KIND_LOOKUP: begin
            st_nxt = hit_r ? ST_DONE : ST_ABSENT;
          end
          KIND_INSERT: begin
            if (val_r[VAL_W-1]) begin
              st_nxt = ST_INVALID;
            end else if (hit_r) begin
              st_nxt = ST_DUP;
            end else if (cnt_r == FULL_CNT) begin
              st_nxt = ST_FULL;
            end else begin
              st_nxt    = ST_DONE;
              sh_nxt    = cnt_r;
              done_nxt  = 1'b0;
              state_nxt = S_INS_RD;
            end
          end
          KIND_REMOVE: begin
            if (hit_r) begin
              st_nxt    = ST_DONE;
              sh_nxt    = idx_r;
              done_nxt  = 1'b0;
              state_nxt = S_RM_RD;
            end else begin
              st_nxt = ST_ABSENT;
            end
          end
          default: begin
            st_nxt = ST_DONE;
          end
        endcase
      end
      S_INS_RD: begin
        if (sh_r == idx_r) begin
          mem_we    = 1'b1;
          mem_waddr = idx_r[AW-1:0];
          cnt_nxt   = cnt_r + ONE;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_raddr = AW'(sh_r - ONE);
          state_nxt = S_INS_WR;
        end
      end
      S_INS_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r[AW-1:0];
        mem_wdata = rdata_r;
        sh_nxt    = sh_r - ONE;
        state_nxt = S_INS_RD;
      end
      S_RM_RD: begin
        if ((sh_r + ONE) == cnt_r) begin
          cnt_nxt   = cnt_r - ONE;
          done_nxt  = 1'b1;
          state_nxt = S_IDLE;
        end else begin
          mem_raddr = AW'(sh_r + ONE);
          state_nxt = S_RM_WR;
        end
      end
      S_RM_WR: begin
        mem_we    = 1'b1;
        mem_waddr = sh_r[AW-1:0];
        mem_wdata = rdata_r;
        sh_nxt    = sh_r + ONE;
        state_nxt = S_RM_RD;
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  assign out_valid       = out_valid_r;
  assign out_found       = out_found_r;
  assign out_found_value = out_fval_r;
  assign out_status      = out_status_r;

endmodule

`default_nettype wire

[rtl/skvt_checker.sv]
// ----------------------------------------------------------------------------
// skvt_checker
// Port-level checks on the sorted key/value table results.
// ----------------------------------------------------------------------------
`default_nettype none

`include "sorted_key_value_table_defines.svh"

module skvt_checker (
  input  wire logic                                clk,
  input  wire logic                                rst_n,
  input  wire logic                                out_valid,
  input  wire logic                                out_stall,
  input  wire logic                                out_found,
  input  wire logic signed [skvt_pkg::VAL_W-1:0]   out_found_value,
  input  wire logic [skvt_pkg::STATUS_W-1:0]       out_status
);

  import skvt_pkg::*;

  logic                              out_wait;
  logic                              found_out;
  logic                              miss_out;
  logic                              miss_code;
  logic [1+VAL_W+STATUS_W-1:0]       out_word;

  assign out_wait  = out_valid && out_stall;
  assign found_out = out_valid && out_found;
  assign miss_out  = out_valid && !out_found;
  assign miss_code = (out_status == ST_ABSENT) || (out_status == ST_FULL);
  assign out_word  = {out_found, out_found_value, out_status};

  `SKVT_ASSERT_NXT(a_out_hold, out_wait, out_valid && $stable(out_word), "stalled word changed")

  `SKVT_ASSERT_IMP(a_absent_value, miss_out, out_found_value == NO_VALUE, "absent key not -1")

  `SKVT_ASSERT_IMP(a_found_status, found_out, !miss_code, "found key reported absent")

  `SKVT_ASSERT_IMP(a_status_code, out_valid, out_status <= ST_ABSENT, "undefined status code")

  `SKVT_ASSERT_IMP(a_found_sign, found_out, !out_found_value[VAL_W-1], "negative stored value")

endmodule

bind sorted_key_value_table skvt_checker u_skvt_checker (.*);

`default_nettype wire
